// ===== rtl/core/adtc_pkg.sv =====
// ----------------------------------------------------------------------------
// adtc_pkg
// Shared types, constants and arithmetic helpers of the tour cost evaluator.
// ----------------------------------------------------------------------------
package adtc_pkg;

  localparam int unsigned MaxHorizon = 255;
  localparam int unsigned ProbW      = 24;
  localparam int unsigned MoneyW     = 24;
  localparam int unsigned CostW      = 40;
  localparam int unsigned HorzW      = 8;
  localparam int unsigned TravW      = 8;
  localparam int unsigned OpenW      = 9;
  localparam int unsigned CloseW     = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned RecW       = 33;
  localparam int unsigned ProdW      = ProbW + RecW;
  localparam int unsigned RndW       = 26;
  localparam int unsigned DivSteps   = 32;

  localparam logic [ProbW-1:0] ProbOne  = 24'h800000;
  localparam logic [ProbW-1:0] EntryMax = 24'hFFFFFF;
  localparam logic [HorzW-1:0] HorizonReset = 8'd255;

  localparam logic [CfgIdxW-1:0] RegHorizon = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMiss    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLate    = 2'd2;

  typedef enum logic [3:0] {
    ST_WIPE, ST_IDLE, ST_DIV, ST_RECIP, ST_SHARE, ST_STREAM, ST_MASS1,
    ST_MASS2, ST_MULA, ST_MULB, ST_COST, ST_MULC, ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_WIPE, OP_DIV, OP_RECIP, OP_SHARE, OP_STREAM,
    OP_MASS1, OP_MASS2, OP_MULA, OP_MULB, OP_COST, OP_MULC, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic travel_zero;
    logic depot;
    logic out_busy;
  } status_t;

  function automatic logic [RndW-1:0] round_money(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + (ProdW+1)'(1 << 22);
    return RndW'(s >> 23);
  endfunction

  function automatic logic signed [CostW-1:0] sat_cost(input logic signed [CostW+1:0] v);
    logic signed [CostW+1:0] hi;
    logic signed [CostW+1:0] lo;
    hi = (CostW+2)'({1'b0, {(CostW-1){1'b1}}});
    lo = -hi - (CostW+2)'(1);
    if (v > hi) return CostW'(hi);
    if (v < lo) return CostW'(lo);
    return CostW'(v);
  endfunction

endpackage

// ===== rtl/core/arrival_distribution_tour_cost.sv =====
// ----------------------------------------------------------------------------
// arrival_distribution_tour_cost
// Expected cost of a tour with uniform travel times and stop time windows.
// ----------------------------------------------------------------------------
// One stop is in work at a time. A stop with nonzero travel runs the
// reciprocal divider, the share pass over the departure memory and the
// convolution and fold stream, both one slot per cycle on the memory ports,
// then the mass, multiply and cost steps. Zero travel skips the divider and
// the share pass. A depot stop adds a point-mass rewrite of all
// MAX_HORIZON+2 entries. After reset the same rewrite runs before the first
// stop is taken; configuration writes are always taken. A waiting result
// does not stall the next stop until another depot result is ready.
module arrival_distribution_tour_cost #(
  parameter int unsigned MAX_HORIZON = adtc_pkg::MaxHorizon
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [adtc_pkg::TravW-1:0]        in_travel_slots_i,
  input  logic [adtc_pkg::OpenW-1:0]        in_window_open_i,
  input  logic [adtc_pkg::CloseW-1:0]       in_window_close_i,
  input  logic [adtc_pkg::MoneyW-1:0]       in_stop_reward_i,
  input  logic                              in_is_depot_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [adtc_pkg::CostW-1:0] out_expected_cost_o,
  output logic [adtc_pkg::ProbW-1:0]        out_late_probability_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [adtc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [adtc_pkg::CfgDataW-1:0]     cfg_data_i
);
  import adtc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  adtc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  adtc_dp #(.MAX_HORIZON(MAX_HORIZON)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .in_travel_slots_i,
    .in_window_open_i,
    .in_window_close_i,
    .in_stop_reward_i,
    .in_is_depot_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_expected_cost_o,
    .out_late_probability_o
  );

  a_one_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("stop taken while another is in work");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result posted without point-mass rewrite");

  a_late_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_late_probability_o <= ProbOne)
    else $error("late probability above one");

endmodule

// ===== rtl/core/adtc_ram.sv =====
// ----------------------------------------------------------------------------
// adtc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module adtc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 257
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/adtc_ctrl.sv =====
// ----------------------------------------------------------------------------
// adtc_ctrl
// Sequencer of the tour cost evaluator: steps the datapath through its passes.
// ----------------------------------------------------------------------------
module adtc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  adtc_pkg::status_t status_i,
  output adtc_pkg::cmd_t    cmd_o
);
  import adtc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIPE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_WIPE:   if (status_i.cnt_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.travel_zero ? ST_STREAM : ST_DIV;
      end
      ST_DIV:    if (status_i.cnt_done) state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_SHARE;
      ST_SHARE:  if (status_i.cnt_done) state_d = ST_STREAM;
      ST_STREAM: if (status_i.cnt_done) state_d = ST_MASS1;
      ST_MASS1:  state_d = ST_MASS2;
      ST_MASS2:  state_d = ST_MULA;
      ST_MULA:   state_d = ST_MULB;
      ST_MULB:   state_d = ST_COST;
      ST_COST:   state_d = status_i.depot ? ST_MULC : ST_IDLE;
      ST_MULC:   state_d = ST_EMIT;
      ST_EMIT:   if (!status_i.out_busy) state_d = ST_WIPE;
      default:   state_d = ST_WIPE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_WIPE:   cmd_o.op = OP_WIPE;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_DIV:    cmd_o.op = OP_DIV;
      ST_RECIP:  cmd_o.op = OP_RECIP;
      ST_SHARE:  cmd_o.op = OP_SHARE;
      ST_STREAM: cmd_o.op = OP_STREAM;
      ST_MASS1:  cmd_o.op = OP_MASS1;
      ST_MASS2:  cmd_o.op = OP_MASS2;
      ST_MULA:   cmd_o.op = OP_MULA;
      ST_MULB:   cmd_o.op = OP_MULB;
      ST_COST:   cmd_o.op = OP_COST;
      ST_MULC:   cmd_o.op = OP_MULC;
      ST_EMIT:   if (!status_i.out_busy) cmd_o.op = OP_EMIT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/adtc_dp.sv =====
// ----------------------------------------------------------------------------
// adtc_dp
// Datapath: distribution memories, reciprocal divider, convolution and fold
// stream, money multiplier and result register.
// ----------------------------------------------------------------------------
module adtc_dp #(
  parameter int unsigned MAX_HORIZON = adtc_pkg::MaxHorizon
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  adtc_pkg::cmd_t                      cmd_i,
  output adtc_pkg::status_t                   status_o,
  input  logic [adtc_pkg::TravW-1:0]          in_travel_slots_i,
  input  logic [adtc_pkg::OpenW-1:0]          in_window_open_i,
  input  logic [adtc_pkg::CloseW-1:0]         in_window_close_i,
  input  logic [adtc_pkg::MoneyW-1:0]         in_stop_reward_i,
  input  logic                                in_is_depot_i,
  input  logic                                cfg_valid_i,
  input  logic [adtc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [adtc_pkg::CfgDataW-1:0]       cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [adtc_pkg::CostW-1:0]   out_expected_cost_o,
  output logic [adtc_pkg::ProbW-1:0]          out_late_probability_o
);
  import adtc_pkg::*;

  localparam int unsigned Depth = MAX_HORIZON + 2;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned IW    = $clog2(Depth + 1);
  localparam int unsigned AccW  = ProbW + IW;

  // configuration
  logic [HorzW-1:0]  horizon_q;
  logic [MoneyW-1:0] miss_q, late_pen_q;

  // captured item
  logic [TravW-1:0]  travel_q;
  logic [IW-1:0]     open_q, close_q;
  logic [MoneyW-1:0] reward_q;
  logic              depot_q;

  // control registers
  logic [IW-1:0] idx_q;
  logic          sh1_v_q, sh2_v_q, st1_v_q, out_valid_q;

  // payload registers
  logic [AW-1:0]           sh1_a_q, sh2_a_q, st1_a_q;
  logic                    st1_ga_q, st1_gb_q, st1_last_q;
  logic [8:0]              rem_q;
  logic [DivSteps-1:0]     quo_q;
  logic [RecW-1:0]         recip_q;
  logic [ProdW-1:0]        prod_q;
  logic [ProbW-1:0]        s_q, m1_q, m2_q;
  logic [AccW-1:0]         acc1_q, acc2_q;
  logic [RndW-1:0]         t1_q;
  logic signed [CostW-1:0] cost_q, out_cost_q;
  logic [ProbW-1:0]        out_late_q;

  logic [IW-1:0] h, h1, h2, cnt_end;
  logic          counting, cnt_done, in_fire;

  always_comb begin
    h  = (int'(horizon_q) > int'(MAX_HORIZON)) ? IW'(MAX_HORIZON) : IW'(horizon_q);
    h1 = h + IW'(1);
    h2 = h + IW'(2);
  end

  always_comb begin
    counting = 1'b1;
    unique case (cmd_i.op)
      OP_DIV:    cnt_end = IW'(DivSteps - 1);
      OP_SHARE:  cnt_end = h1;
      OP_STREAM: cnt_end = h2;
      OP_WIPE:   cnt_end = IW'(Depth - 1);
      default: begin
        cnt_end  = '0;
        counting = 1'b0;
      end
    endcase
  end

  assign cnt_done = counting && (idx_q == cnt_end);
  assign in_fire  = (cmd_i.op == OP_LOAD);

  // memories
  logic             dep_we, sh_we;
  logic [AW-1:0]    dep_waddr, dep_raddr, sha_raddr, shb_raddr;
  logic [ProbW-1:0] dep_wdata, dep_rd, sha_rd, shb_rd, sh_wdata;

  adtc_ram #(.Width(ProbW), .Depth(Depth)) u_dep_ram (
    .clk_i, .we_i(dep_we), .waddr_i(dep_waddr), .wdata_i(dep_wdata),
    .raddr_i(dep_raddr), .rdata_o(dep_rd)
  );

  adtc_ram #(.Width(ProbW), .Depth(Depth)) u_sha_ram (
    .clk_i, .we_i(sh_we), .waddr_i(sh2_a_q), .wdata_i(sh_wdata),
    .raddr_i(sha_raddr), .rdata_o(sha_rd)
  );

  adtc_ram #(.Width(ProbW), .Depth(Depth)) u_shb_ram (
    .clk_i, .we_i(sh_we), .waddr_i(sh2_a_q), .wdata_i(sh_wdata),
    .raddr_i(shb_raddr), .rdata_o(shb_rd)
  );

  assign sh_we    = sh2_v_q;
  assign sh_wdata = prod_q[RecW-1+ProbW-1:RecW-1];
  assign dep_raddr = idx_q[AW-1:0];
  assign sha_raddr = AW'(int'(idx_q) - 1);
  assign shb_raddr = AW'(int'(idx_q) - 1 - int'(travel_q));

  // stream stage
  logic [ProbW-1:0] s_next, raw, stored, open_sat;
  logic [AccW-1:0]  acc1_new;
  logic             in_first, in_second, st_wr;

  always_comb begin
    s_next    = s_q + (st1_ga_q ? sha_rd : '0) - (st1_gb_q ? shb_rd : '0);
    raw       = (travel_q == '0) ? dep_rd : (st1_last_q ? '0 : s_next);
    in_first  = (IW'(st1_a_q) <= open_q) || (IW'(st1_a_q) <= close_q);
    in_second = (IW'(st1_a_q) > close_q) && (IW'(st1_a_q) <= h);
    acc1_new  = acc1_q + AccW'(raw);
    open_sat  = (acc1_new > AccW'(EntryMax)) ? EntryMax : acc1_new[ProbW-1:0];
    if (IW'(st1_a_q) < open_q) begin
      stored = '0;
    end else if (IW'(st1_a_q) == open_q) begin
      stored = open_sat;
    end else begin
      stored = raw;
    end
    st_wr = st1_v_q && (IW'(st1_a_q) <= h);
  end

  always_comb begin
    dep_we    = 1'b0;
    dep_waddr = st1_a_q;
    dep_wdata = stored;
    priority if (cmd_i.op == OP_WIPE) begin
      dep_we    = 1'b1;
      dep_waddr = idx_q[AW-1:0];
      dep_wdata = (idx_q == '0) ? ProbOne : '0;
    end else if (st_wr) begin
      dep_we = 1'b1;
    end else if (cmd_i.op == OP_COST && !depot_q) begin
      dep_we    = 1'b1;
      dep_waddr = h1[AW-1:0];
      dep_wdata = ProbOne - m2_q;
    end
  end

  // cost arithmetic
  logic [ProbW-1:0]        m1_c, m2_c;
  logic [AccW-1:0]         m2_sum;
  logic [8:0]              rem_t;
  logic signed [CostW+1:0] cost_sum, emit_sum;

  always_comb begin
    m1_c     = (acc1_q > AccW'(ProbOne)) ? ProbOne : acc1_q[ProbW-1:0];
    m2_sum   = AccW'(m1_q) + acc2_q;
    m2_c     = (m2_sum > AccW'(ProbOne)) ? ProbOne : m2_sum[ProbW-1:0];
    rem_t    = {rem_q[7:0], 1'b1};
    cost_sum = (CostW+2)'(cost_q) + $signed((CostW+2)'(t1_q))
             - $signed((CostW+2)'(round_money(prod_q)));
    emit_sum = (CostW+2)'(cost_q) + $signed((CostW+2)'(round_money(prod_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      horizon_q   <= HorizonReset;
      miss_q      <= '0;
      late_pen_q  <= '0;
      idx_q       <= '0;
      sh1_v_q     <= 1'b0;
      sh2_v_q     <= 1'b0;
      st1_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cost_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegHorizon: horizon_q  <= cfg_data_i[HorzW-1:0];
          RegMiss:    miss_q     <= cfg_data_i;
          RegLate:    late_pen_q <= cfg_data_i;
          default:    ;
        endcase
      end
      idx_q   <= (counting && !cnt_done) ? idx_q + IW'(1) : '0;
      sh1_v_q <= (cmd_i.op == OP_SHARE) && (idx_q < h);
      sh2_v_q <= sh1_v_q;
      st1_v_q <= (cmd_i.op == OP_STREAM) && (idx_q <= h1);
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.op == OP_COST) begin
        cost_q <= sat_cost(cost_sum);
      end else if (cmd_i.op == OP_EMIT) begin
        cost_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      travel_q <= in_travel_slots_i;
      open_q   <= (int'(in_window_open_i) > int'(h1)) ? h1 : IW'(in_window_open_i);
      close_q  <= (int'(in_window_close_i) > int'(h)) ? h : IW'(in_window_close_i);
      reward_q <= in_stop_reward_i;
      depot_q  <= in_is_depot_i;
      rem_q    <= '0;
      quo_q    <= '0;
      s_q      <= '0;
      acc1_q   <= '0;
      acc2_q   <= '0;
    end
    if (cmd_i.op == OP_DIV) begin
      if (rem_t >= {1'b0, travel_q}) begin
        rem_q <= rem_t - {1'b0, travel_q};
        quo_q <= {quo_q[DivSteps-2:0], 1'b1};
      end else begin
        rem_q <= rem_t;
        quo_q <= {quo_q[DivSteps-2:0], 1'b0};
      end
    end
    if (cmd_i.op == OP_RECIP) begin
      recip_q <= {1'b0, quo_q} + RecW'(1);
    end
    sh1_a_q <= idx_q[AW-1:0];
    sh2_a_q <= sh1_a_q;
    if (sh1_v_q) begin
      prod_q <= ProdW'(dep_rd) * ProdW'(recip_q);
    end
    st1_a_q    <= idx_q[AW-1:0];
    st1_ga_q   <= (idx_q != '0) && (idx_q <= h);
    st1_gb_q   <= (int'(idx_q) > int'(travel_q)) && (idx_q <= h);
    st1_last_q <= (idx_q == h1);
    if (st1_v_q) begin
      s_q <= s_next;
      if (in_first) acc1_q <= acc1_new;
      if (in_second) acc2_q <= acc2_q + AccW'(stored);
    end
    unique case (cmd_i.op)
      OP_MASS1: m1_q <= m1_c;
      OP_MASS2: m2_q <= m2_c;
      OP_MULA:  prod_q <= ProdW'(ProbOne - m1_q) * ProdW'(miss_q);
      OP_MULB: begin
        t1_q   <= round_money(prod_q);
        prod_q <= ProdW'(m1_q) * ProdW'(reward_q);
      end
      OP_MULC:  prod_q <= ProdW'(ProbOne - m2_q) * ProdW'(late_pen_q);
      OP_EMIT: begin
        out_cost_q <= sat_cost(emit_sum);
        out_late_q <= ProbOne - m2_q;
      end
      default: ;
    endcase
  end

  assign status_o.cnt_done    = cnt_done;
  assign status_o.travel_zero = (in_travel_slots_i == '0);
  assign status_o.depot       = depot_q;
  assign status_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o            = out_valid_q;
  assign out_expected_cost_o    = out_cost_q;
  assign out_late_probability_o = out_late_q;

endmodule
